### sv/wstc_pkg.sv
package wstc_pkg;

  // Field widths of one pixel word and one result word.
  localparam int unsigned PixW    = 8;
  localparam int unsigned CoordW  = 11;
  localparam int unsigned WinW    = 10;
  localparam int unsigned CentW   = 19;
  localparam int unsigned MassW   = 28;
  localparam int unsigned MomW    = 40;
  localparam int unsigned WeightW = 17;
  localparam int unsigned MassCW  = 17;
  localparam int unsigned ProdW   = CoordW + MassCW;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 28;
  localparam logic [CfgIdxW-1:0] RegPixelThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMassThreshold  = 2'd1;
  localparam logic [PixW-1:0]  PixThrReset  = 8'd70;
  localparam logic [MassW-1:0] MassThrReset = 28'd196608;

  // Weight table: 256 entries, built after reset.
  localparam int unsigned TabDepth = 256;
  localparam int unsigned TabAddrW = 8;
  localparam logic [TabAddrW-1:0] LowReach = 8'd56;

  // Shared divider widths.
  localparam int unsigned DivNumW = 49;
  localparam int unsigned DivDenW = 34;
  localparam int unsigned DivCntW = 6;

  // Sigmoid recurrence: ratio exp(-2/17) in Q0.32.
  localparam int unsigned PW = 33;
  localparam logic [31:0] RatioQ32 = 32'd3818267867;
  localparam logic [CentW-1:0] CentMax = '1;

  // Dividend selection for the shared divider.
  typedef enum logic [1:0] {
    DIV_TABLE = 2'd0,
    DIV_COL   = 2'd1,
    DIV_ROW   = 2'd2
  } div_sel_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic     pix_load;
    logic     tab_read;
    logic     wt_load;
    logic     scale_load;
    logic     fix_load;
    logic     prod_load;
    logic     acc_load;
    logic     found_load;
    logic     div_start;
    div_sel_e div_sel;
    logic     capx_load;
    logic     capy_load;
    logic     emit_load;
    logic     tab_write;
    logic     p_step;
  } wstc_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic div_done;
    logic found;
    logic last;
    logic tab_last;
    logic can_emit;
  } wstc_status_t;

endpackage

### sv/wstc_ram.sv
module wstc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/wstc_div.sv
module wstc_div
  import wstc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quo_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW:0]   trial;
  logic               fits;

  // One quotient bit per cycle, restoring.
  always_comb begin
    trial  = {rem_q, quo_q[DivNumW-1]};
    fits   = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivNumW);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DivNumW-2:0], fits};
      rem_d = fits ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### sv/wstc_datapath.sv
module wstc_datapath
  import wstc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wstc_cmd_t            cmd_i,
  output wstc_status_t         status_o,
  input  logic [PixW-1:0]      pix_value_i,
  input  logic [CoordW-1:0]    pix_column_i,
  input  logic [CoordW-1:0]    pix_row_i,
  input  logic [WinW-1:0]      pix_window_i,
  input  logic                 pix_last_i,
  input  logic                 cfg_write_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WinW-1:0]      out_window_o,
  output logic [CentW-1:0]     out_cx_o,
  output logic [CentW-1:0]     out_cy_o,
  output logic                 out_found_o
);

  // Configuration registers.
  logic [PixW-1:0]  pthr_q;
  logic [MassW-1:0] mthr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pthr_q <= PixThrReset;
      mthr_q <= MassThrReset;
    end else if (cfg_write_i) begin
      if (cfg_index_i == RegPixelThreshold) begin
        pthr_q <= cfg_data_i[PixW-1:0];
      end else if (cfg_index_i == RegMassThreshold) begin
        mthr_q <= cfg_data_i[MassW-1:0];
      end
    end
  end

  // Pixel word being worked on.
  logic [PixW-1:0]   v_q;
  logic [CoordW-1:0] col_q, row_q;
  logic [WinW-1:0]   win_q;
  logic              last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      v_q    <= pix_value_i;
      col_q  <= pix_column_i;
      row_q  <= pix_row_i;
      win_q  <= pix_window_i;
      last_q <= pix_last_i;
    end
  end

  // Distance from the threshold picks the table entry.
  logic [PixW:0]     diff;
  logic              neg_d;
  logic [TabAddrW-1:0] mag;
  logic              act_d;
  logic              neg_q, act_q;

  assign diff  = {1'b0, v_q} - {1'b0, pthr_q};
  assign neg_d = diff[PixW];
  assign mag   = neg_d ? TabAddrW'(-diff) : diff[TabAddrW-1:0];
  assign act_d = !neg_d || (mag <= LowReach);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tab_read) begin
      neg_q <= neg_d;
      act_q <= act_d;
    end
  end

  // Table build state: recurrence value and entry counter.
  logic [PW-1:0]        p_q;
  logic [TabAddrW-1:0]  k_q;
  logic [PW+32-1:0]     p_mul;
  logic [DivDenW-1:0]   den_tab;
  logic [DivNumW-1:0]   num_tab;

  assign p_mul   = p_q * RatioQ32;
  assign den_tab = (DivDenW'(1) << 32) + DivDenW'(p_q);
  assign num_tab = (DivNumW'(1) << 48) + DivNumW'(den_tab >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= PW'(1) << 32;
      k_q <= '0;
    end else if (cmd_i.p_step) begin
      p_q <= PW'((p_mul + (PW'(1) << 31)) >> 32);
      k_q <= k_q + 1'b1;
    end
  end

  // Weight table memory.
  logic [WeightW-1:0] w_pos;
  logic [DivNumW-1:0] quo;
  logic               div_done;

  wstc_ram #(
    .Width (WeightW),
    .Depth (TabDepth)
  ) u_tab (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tab_write),
    .waddr_i (k_q),
    .wdata_i (quo[WeightW-1:0]),
    .re_i    (cmd_i.tab_read),
    .raddr_i (mag),
    .rdata_o (w_pos)
  );

  // Weighted intensity numerator v*w + 127.
  logic [WeightW-1:0] w;
  logic [24:0]        x_q;

  assign w = neg_q ? WeightW'(WeightW'(1) << 16) - w_pos : w_pos;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wt_load) begin
      x_q <= 25'(v_q * w) + 25'd127;
    end
  end

  // Divide by 255: estimate with x*257/65536, then correct up to two.
  logic [24:0]       q0_q;
  logic [24:0]       r0;
  logic [MassCW-1:0] c_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_load) begin
      q0_q <= 25'(({8'd0, x_q} + ({8'd0, x_q} << 8)) >> 16);
    end
  end

  assign r0 = x_q - ((q0_q << 8) - q0_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fix_load) begin
      if (!act_q) begin
        c_q <= '0;
      end else if (r0 >= 25'd510) begin
        c_q <= MassCW'(q0_q + 25'd2);
      end else if (r0 >= 25'd255) begin
        c_q <= MassCW'(q0_q + 25'd1);
      end else begin
        c_q <= MassCW'(q0_q);
      end
    end
  end

  // Moment products.
  logic [ProdW-1:0] pc_q, pr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_load) begin
      pc_q <= col_q * c_q;
      pr_q <= row_q * c_q;
    end
  end

  // Saturating accumulators, cleared when the result is written out.
  logic [MassW-1:0] mass_q;
  logic [MomW-1:0]  momc_q, momr_q;
  logic [MassW:0]   mass_s;
  logic [MomW:0]    momc_s, momr_s;

  assign mass_s = {1'b0, mass_q} + (MassW+1)'(c_q);
  assign momc_s = {1'b0, momc_q} + (MomW+1)'(pc_q);
  assign momr_s = {1'b0, momr_q} + (MomW+1)'(pr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= '0;
      momc_q <= '0;
      momr_q <= '0;
    end else if (cmd_i.emit_load) begin
      mass_q <= '0;
      momc_q <= '0;
      momr_q <= '0;
    end else if (cmd_i.acc_load) begin
      mass_q <= mass_s[MassW] ? '1 : mass_s[MassW-1:0];
      momc_q <= momc_s[MomW] ? '1 : momc_s[MomW-1:0];
      momr_q <= momr_s[MomW] ? '1 : momr_s[MomW-1:0];
    end
  end

  // Mass check.
  logic found_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.found_load) begin
      found_q <= mass_q > mthr_q;
    end
  end

  // Shared divider: table entries and both centroids.
  logic [DivNumW-1:0] num;
  logic [DivDenW-1:0] den;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_TABLE: begin
        num = num_tab;
        den = den_tab;
      end
      DIV_COL: begin
        num = (DivNumW'(momc_q) << 8) + DivNumW'(mass_q >> 1);
        den = DivDenW'(mass_q);
      end
      DIV_ROW: begin
        num = (DivNumW'(momr_q) << 8) + DivNumW'(mass_q >> 1);
        den = DivDenW'(mass_q);
      end
      default: begin
        num = num_tab;
        den = den_tab;
      end
    endcase
  end

  wstc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Clamped centroids.
  logic [CentW-1:0] cx_q, cy_q;
  logic [CentW-1:0] quo_sat;

  assign quo_sat = (quo > DivNumW'(CentMax)) ? CentMax : quo[CentW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capx_load) begin
      cx_q <= quo_sat;
    end
    if (cmd_i.capy_load) begin
      cy_q <= quo_sat;
    end
  end

  // Output register.
  logic             ovalid_q;
  logic [WinW-1:0]  owin_q;
  logic [CentW-1:0] ocx_q, ocy_q;
  logic             ofound_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      owin_q   <= win_q;
      ocx_q    <= found_q ? cx_q : '0;
      ocy_q    <= found_q ? cy_q : '0;
      ofound_q <= found_q;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_window_o = owin_q;
  assign out_cx_o     = ocx_q;
  assign out_cy_o     = ocy_q;
  assign out_found_o  = ofound_q;

  assign status_o.div_done = div_done;
  assign status_o.found    = found_q;
  assign status_o.last     = last_q;
  assign status_o.tab_last = k_q == '1;
  assign status_o.can_emit = !ovalid_q || out_ready_i;

endmodule

### sv/wstc_ctrl.sv
module wstc_ctrl
  import wstc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  wstc_status_t status_i,
  output wstc_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_TAB_DIV,
    S_TAB_WAIT,
    S_TAB_STEP,
    S_IDLE,
    S_LOOK,
    S_WEIGHT,
    S_SCALE,
    S_FIX,
    S_PROD,
    S_ACC,
    S_CHECK,
    S_DIVX,
    S_DIVY,
    S_CAPY,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = DIV_TABLE;
    case (state_q)
      S_TAB_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_TAB_WAIT;
      end
      S_TAB_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.tab_write = 1'b1;
          state_d = status_i.tab_last ? S_IDLE : S_TAB_STEP;
        end
      end
      S_TAB_STEP: begin
        cmd_o.p_step = 1'b1;
        state_d = S_TAB_DIV;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.pix_load = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.tab_read = 1'b1;
        state_d = S_WEIGHT;
      end
      S_WEIGHT: begin
        cmd_o.wt_load = 1'b1;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale_load = 1'b1;
        state_d = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix_load = 1'b1;
        state_d = S_PROD;
      end
      S_PROD: begin
        cmd_o.prod_load = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_load = 1'b1;
        state_d = status_i.last ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        cmd_o.found_load = 1'b1;
        state_d = S_DIVX;
      end
      S_DIVX: begin
        if (!status_i.found) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_COL;
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        if (status_i.div_done) begin
          cmd_o.capx_load = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_ROW;
          state_d = S_CAPY;
        end
      end
      // Wait for the row quotient.
      S_CAPY: begin
        if (status_i.div_done) begin
          cmd_o.capy_load = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.can_emit) begin
          cmd_o.emit_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_TAB_DIV;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

### sv/windowed_soft_threshold_centroid.sv
// Soft-threshold center-of-mass centroid for one lenslet window at a time.
// Pixel words enter on the s_axis channel with tlast on the final pixel of a
// window. A pixel is not taken until the previous one has been accumulated;
// the sequencer walks through table lookup, weighting, scaling by 1/255,
// moment products and saturating accumulation.
// On the last pixel the mass is compared with mass_threshold. When found,
// both centroids, column then row, come from one shared radix-2 divider
// before the result is registered; otherwise the result skips the divider.
// The result word waits in an output register; the next window's pixels are
// accepted meanwhile, and only the next result waits for m_axis_tready.
// After reset the 256-entry sigmoid weight table is built in place, one
// entry per divider quotient; s_axis_tready stays
// low during that time. Configuration writes are taken at any time but are
// meant for idle periods.
module windowed_soft_threshold_centroid
  import wstc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pixel_value[7:0], pixel_column[18:8], pixel_row[29:19], window_index[39:30]
  input  logic [39:0]         s_axis_tdata,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // result_window[9:0], centroid_x[28:10], centroid_y[47:29]
  output logic [47:0]         m_axis_tdata,
  // found[0]
  output logic                m_axis_tuser,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  wstc_cmd_t        cmd;
  wstc_status_t     status;
  logic [WinW-1:0]  owin;
  logic [CentW-1:0] ocx, ocy;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  wstc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  wstc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .pix_value_i  (s_axis_tdata[7:0]),
    .pix_column_i (s_axis_tdata[18:8]),
    .pix_row_i    (s_axis_tdata[29:19]),
    .pix_window_i (s_axis_tdata[39:30]),
    .pix_last_i   (s_axis_tlast),
    .cfg_write_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_window_o (owin),
    .out_cx_o     (ocx),
    .out_cy_o     (ocy),
    .out_found_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {ocy, ocx, owin};

endmodule
